/* design/pptn_pkg.sv */
package pptn_pkg;

  // quaternion component and rotation matrix entry widths
  localparam int QW = 16;
  localparam int MW = 35;

  // divider: 16 quotient bits over DIV_STAGES registers, DIV_STEPS bits each
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = 4;

  typedef logic [31:0] div_acc_t;

  typedef enum logic [2:0] {
    REG_POSE_QUAT   = 3'd0,
    REG_SHIFT_X     = 3'd1,
    REG_SHIFT_Y     = 3'd2,
    REG_SHIFT_Z     = 3'd3,
    REG_RANGE_LIMIT = 3'd4,
    REG_INT_LIMITS  = 3'd5,
    REG_COLOR_OFFS  = 3'd6,
    REG_COLOR_SPANS = 3'd7
  } cfg_reg_t;

  // per-beat attribute flags carried alongside the divider pipeline
  typedef struct packed {
    logic        use_fix;
    logic [15:0] norm_fix;
    logic [7:0]  gray_fix;
    logic        sat_n;
    logic        sat_g;
    logic [2:0]  c_zero;
    logic [2:0]  c_sat;
  } attr_t;

  // restoring division steps: acc holds {remainder, dividend/quotient bits}
  function automatic div_acc_t div_chunk(div_acc_t acc, logic [15:0] span);
    div_acc_t    a;
    logic [16:0] t;
    logic [16:0] s;
    a = acc;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {a[31:16], a[15]};
      s = t - {1'b0, span};
      if (t >= {1'b0, span}) begin
        a = {s[15:0], a[14:0], 1'b1};
      end else begin
        a = {t[15:0], a[14:0], 1'b0};
      end
    end
    return a;
  endfunction

endpackage

/* design/pptn_div.sv */
module pptn_div
  import pptn_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  div_acc_t    acc_in,
  input  logic [15:0] span,
  output logic [15:0] quo
);

  div_acc_t st [DIV_STAGES];

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= div_chunk(acc_in, span);
      for (int s = 1; s < DIV_STAGES; s++) begin
        st[s] <= div_chunk(st[s-1], span);
      end
    end
  end

  assign quo = st[DIV_STAGES-1][15:0];

endmodule

/* design/point_pose_transform_normalize_top.sv */
// throughput one point per cycle while the output register is empty or m_tready is high
// the rate is set by the six-stage pipeline (products, row sums, rounding,
// squares and saturation, range compare, output register) and the 16-bit divider
// running four quotient bits per stage; a full stage set stalls together
// rotation matrix follows a pose write through the product registers and the matrix register
// rst (synchronous) clears valid bits and loads register defaults, identity pose
module point_pose_transform_normalize_top
  import pptn_pkg::*;
#(
  parameter int COORD_WIDTH = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [2:0]             cfg_index,
  input  logic [63:0]            cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // pos_x, pos_y, pos_z, raw_intensity, raw_red, raw_green, raw_blue, zero pad
  input  logic [((3*COORD_WIDTH+64+7)/8)*8-1:0] s_tdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // world_x, world_y, world_z, norm_intensity, red_out, green_out, blue_out, zero pad
  output logic [((3*COORD_WIDTH+40+7)/8)*8-1:0] m_tdata
);

  localparam int CW   = COORD_WIDTH;
  localparam int OW   = ((3*CW+40+7)/8)*8;
  localparam int CHW  = CW - 15;
  localparam int PHW  = MW + CHW;
  localparam int PLW  = MW + 17;
  localparam int HW   = PHW + 2;
  localparam int LW   = PLW + 2;
  localparam int SW   = CW + 23;
  localparam int RW   = SW - 12;

  localparam logic signed [MW-1:0] ONE_Q28  = MW'(30'sh10000000);
  localparam logic signed [LW-1:0] HALF_Q28 = LW'(29'sh08000000);

  // configuration registers
  logic [63:0]          quat;
  logic signed [CW-1:0] shift [3];
  logic [47:0]          lim_sq;
  logic [32:0]          ilim;
  logic [48:0]          coff;
  logic [47:0]          cspan;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat     <= 64'h4000_0000_0000_0000;
      shift[0] <= '0;
      shift[1] <= '0;
      shift[2] <= '0;
      lim_sq   <= '0;
      ilim     <= '0;
      coff     <= '0;
      cspan    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POSE_QUAT:   quat     <= cfg_data;
        REG_SHIFT_X:     shift[0] <= cfg_data[CW-1:0];
        REG_SHIFT_Y:     shift[1] <= cfg_data[CW-1:0];
        REG_SHIFT_Z:     shift[2] <= cfg_data[CW-1:0];
        REG_RANGE_LIMIT: lim_sq   <= cfg_data[47:0];
        REG_INT_LIMITS:  ilim     <= cfg_data[32:0];
        REG_COLOR_OFFS:  coff     <= cfg_data[48:0];
        REG_COLOR_SPANS: cspan    <= cfg_data[47:0];
        default: ;
      endcase
    end
  end

  // rotation matrix from quaternion, two register levels
  logic signed [QW-1:0] qw, qx, qy, qz;
  assign qw = quat[63:48];
  assign qx = quat[47:32];
  assign qy = quat[31:16];
  assign qz = quat[15:0];

  logic signed [31:0] pxx, pyy, pzz, pxy, pxz, pyz, pxw, pyw, pzw;
  logic signed [MW-1:0] m [3][3];

  function automatic logic signed [MW-1:0] sx(logic signed [31:0] p);
    return {{(MW-32){p[31]}}, p};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      pxx <= '0; pyy <= '0; pzz <= '0;
      pxy <= '0; pxz <= '0; pyz <= '0;
      pxw <= '0; pyw <= '0; pzw <= '0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          m[i][j] <= (i == j) ? ONE_Q28 : '0;
        end
      end
    end else begin
      pxx <= qx * qx; pyy <= qy * qy; pzz <= qz * qz;
      pxy <= qx * qy; pxz <= qx * qz; pyz <= qy * qz;
      pxw <= qx * qw; pyw <= qy * qw; pzw <= qz * qw;
      m[0][0] <= ONE_Q28 - ((sx(pyy) + sx(pzz)) <<< 1);
      m[0][1] <= (sx(pxy) - sx(pzw)) <<< 1;
      m[0][2] <= (sx(pxz) + sx(pyw)) <<< 1;
      m[1][0] <= (sx(pxy) + sx(pzw)) <<< 1;
      m[1][1] <= ONE_Q28 - ((sx(pxx) + sx(pzz)) <<< 1);
      m[1][2] <= (sx(pyz) - sx(pxw)) <<< 1;
      m[2][0] <= (sx(pxz) - sx(pyw)) <<< 1;
      m[2][1] <= (sx(pyz) + sx(pxw)) <<< 1;
      m[2][2] <= ONE_Q28 - ((sx(pxx) + sx(pyy)) <<< 1);
    end
  end

  // pipeline control: all stages move together
  logic [5:0] v;
  logic       adv;
  logic       e_keep;

  assign adv      = !v[5] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = v[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[4] && e_keep, v[3:0], s_tvalid};
    end
  end

  // input fields
  logic signed [CW-1:0] pos [3];
  logic [15:0]          raw_intensity;
  logic [15:0]          raw_rgb [3];

  assign pos[0]        = s_tdata[CW-1:0];
  assign pos[1]        = s_tdata[2*CW-1:CW];
  assign pos[2]        = s_tdata[3*CW-1:2*CW];
  assign raw_intensity = s_tdata[3*CW+15:3*CW];
  assign raw_rgb[0]    = s_tdata[3*CW+31:3*CW+16];
  assign raw_rgb[1]    = s_tdata[3*CW+47:3*CW+32];
  assign raw_rgb[2]    = s_tdata[3*CW+63:3*CW+48];

  // stage a: partial products of coordinates split at bit 16
  logic signed [CHW-1:0] ch [3];
  logic signed [16:0]    cl [3];
  logic signed [PHW-1:0] a_ph [3][3];
  logic signed [PLW-1:0] a_pl [3][3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      ch[j] = $signed(pos[j][CW-1:15]) >>> 1;
      cl[j] = {1'b0, pos[j][15:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          a_ph[i][j] <= m[i][j] * ch[j];
          a_pl[i][j] <= m[i][j] * cl[j];
        end
      end
    end
  end

  // stage b: row sums
  logic signed [HW-1:0] b_hi [3];
  logic signed [LW-1:0] b_lo [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        b_hi[i] <= HW'(a_ph[i][0]) + HW'(a_ph[i][1]) + HW'(a_ph[i][2]);
        b_lo[i] <= LW'(a_pl[i][0]) + LW'(a_pl[i][1]) + LW'(a_pl[i][2]) + HALF_Q28;
      end
    end
  end

  // stage c: combine halves, round half up
  logic signed [LW-17:0] lo_top [3];
  logic signed [SW-1:0]  tot [3];
  logic signed [RW-1:0]  c_r [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      lo_top[i] = b_lo[i][LW-1:16];
      tot[i]    = SW'(b_hi[i]) + SW'(lo_top[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        c_r[i] <= tot[i][SW-1:12];
      end
    end
  end

  // stage d: squares for range test, translation with saturation
  logic [RW-1:0]        mag [3];
  logic signed [RW:0]   tsum [3];
  logic                 in_rng [3];
  logic [47:0]          d_sq [3];
  logic [2:0]           d_big;
  logic signed [CW-1:0] d_w [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i]    = c_r[i][RW-1] ? RW'(-c_r[i]) : RW'(c_r[i]);
      tsum[i]   = {c_r[i][RW-1], c_r[i]} + (RW+1)'(shift[i]);
      in_rng[i] = (tsum[i][RW:CW-1] == {(RW-CW+2){tsum[i][RW]}});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        d_sq[i]  <= mag[i][23:0] * mag[i][23:0];
        d_big[i] <= |mag[i][RW-1:24];
        d_w[i]   <= in_rng[i] ? tsum[i][CW-1:0]
                              : {tsum[i][RW], {(CW-1){~tsum[i][RW]}}};
      end
    end
  end

  // stage e: range compare
  logic [49:0]          d2;
  logic signed [CW-1:0] e_w [3];

  assign d2 = 50'(d_sq[0]) + 50'(d_sq[1]) + 50'(d_sq[2]);

  always_ff @(posedge clk) begin
    if (adv) begin
      e_keep <= (lim_sq == '0) || (!(|d_big) && (d2 <= 50'(lim_sq)));
      e_w    <= d_w;
    end
  end

  // attribute setup in stage a
  logic [15:0] i_off, i_span, i_d;
  logic [23:0] i_ng;
  logic [15:0] c_off [3];
  logic [15:0] c_span [3];
  logic [15:0] c_d [3];
  logic [23:0] c_ng [3];
  attr_t       at_in;

  assign i_off  = ilim[31:16];
  assign i_span = ilim[15:0];
  assign i_d    = raw_intensity - i_off;
  assign i_ng   = {i_d, 8'd0} - {8'd0, i_d};

  always_comb begin
    at_in.use_fix  = !ilim[32] || (i_span == '0) || (raw_intensity <= i_off);
    at_in.norm_fix = !ilim[32] ? 16'h8000
                   : ((i_span == '0) && (raw_intensity != '0)) ? 16'hffff : 16'h0000;
    at_in.gray_fix = !ilim[32] ? 8'd127
                   : ((i_span == '0) && (raw_intensity != '0)) ? 8'd255 : 8'd0;
    at_in.sat_n    = i_d >= i_span;
    at_in.sat_g    = i_ng[23:8] >= i_span;
    for (int k = 0; k < 3; k++) begin
      c_off[k]        = coff[47-16*k -: 16];
      c_span[k]       = cspan[47-16*k -: 16];
      c_d[k]          = raw_rgb[k] - c_off[k];
      c_ng[k]         = {c_d[k], 8'd0} - {8'd0, c_d[k]};
      at_in.c_zero[k] = !coff[48] || (c_span[k] == '0) || (raw_rgb[k] <= c_off[k]);
      at_in.c_sat[k]  = c_ng[k][23:8] >= c_span[k];
    end
  end

  div_acc_t a_acc [5];
  attr_t    at [5];

  always_ff @(posedge clk) begin
    if (adv) begin
      a_acc[0] <= {i_d, 16'd0};
      a_acc[1] <= {i_ng, 8'd0};
      a_acc[2] <= {c_ng[0], 8'd0};
      a_acc[3] <= {c_ng[1], 8'd0};
      a_acc[4] <= {c_ng[2], 8'd0};
      at[0]    <= at_in;
      for (int s = 1; s < 5; s++) begin
        at[s] <= at[s-1];
      end
    end
  end

  // divider chains: intensity fraction, gray, red, green, blue
  logic [15:0] quo [5];
  logic [15:0] dspan [5];

  assign dspan[0] = i_span;
  assign dspan[1] = i_span;
  assign dspan[2] = c_span[0];
  assign dspan[3] = c_span[1];
  assign dspan[4] = c_span[2];

  for (genvar g = 0; g < 5; g++) begin : g_div
    pptn_div u_div (
      .clk    (clk),
      .en     (adv),
      .acc_in (a_acc[g]),
      .span   (dspan[g]),
      .quo    (quo[g])
    );
  end

  // stage f: output register
  attr_t       ae;
  logic [15:0] f_norm;
  logic [7:0]  f_gray;
  logic [7:0]  f_ch [3];
  logic [15:0] o_norm;
  logic [7:0]  o_rgb [3];
  logic signed [CW-1:0] o_w [3];

  assign ae = at[4];

  always_comb begin
    f_norm = ae.use_fix ? ae.norm_fix : (ae.sat_n ? 16'hffff : quo[0]);
    f_gray = ae.use_fix ? ae.gray_fix : (ae.sat_g ? 8'd255 : quo[1][15:8]);
    for (int k = 0; k < 3; k++) begin
      f_ch[k] = ae.c_zero[k] ? 8'd0 : (ae.c_sat[k] ? 8'd255 : quo[k+2][15:8]);
    end
    // all-black or no color falls back to gray
    if ((f_ch[0] == '0) && (f_ch[1] == '0) && (f_ch[2] == '0)) begin
      for (int k = 0; k < 3; k++) begin
        f_ch[k] = f_gray;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_w    <= e_w;
      o_norm <= f_norm;
      o_rgb  <= f_ch;
    end
  end

  assign m_tdata = {{(OW-3*CW-40){1'b0}}, o_rgb[2], o_rgb[1], o_rgb[0], o_norm,
                    o_w[2], o_w[1], o_w[0]};

endmodule

/* tb/point_pose_transform_normalize_top_tb.sv */
module point_pose_transform_normalize_top_tb;
  import pptn_pkg::*;

  localparam int CW = 24;
  localparam int SW = ((3*CW+64+7)/8)*8;
  localparam int MWD = ((3*CW+40+7)/8)*8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 225;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [63:0] cfg_data;
  logic s_tvalid;
  logic s_tready;
  logic [SW-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [MWD-1:0] m_tdata;

  point_pose_transform_normalize_top #(.COORD_WIDTH(CW)) dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  // shadow copies of the configuration registers
  logic [63:0] pose_q;
  logic [CW-1:0] shift_x, shift_y, shift_z;
  logic [47:0] range_sq;
  logic [32:0] int_limits;
  logic [48:0] col_offs;
  logic [47:0] col_spans;

  logic [SW-1:0] point_q[$];
  logic [MWD-1:0] world_q[$];
  int errors;
  int cycles;
  int burst_left;
  int gap_left;
  int stall_mode;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    errors++;
  endtask

  function automatic longint sat_coord(input longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  function automatic longint scale_chan(input longint raw, input longint off,
                                        input longint span);
    longint v;
    if (span == 0 || raw <= off) return 0;
    v = ((raw - off) * 255) / span;
    return (v > 255) ? 255 : v;
  endfunction

  // rigid transform plus attribute normalization; returns 0 for a dropped point
  function automatic bit transform_point(input logic [SW-1:0] d,
                                         output logic [MWD-1:0] res);
    longint qw, qx, qy, qz;
    longint m[3][3];
    longint c[3], r[3], w[3], rgb[3];
    longint d2, a, norm, gray, raw_i, off, span;
    qw = longint'($signed(pose_q[63:48]));
    qx = longint'($signed(pose_q[47:32]));
    qy = longint'($signed(pose_q[31:16]));
    qz = longint'($signed(pose_q[15:0]));
    m[0][0] = (64'sd1 <<< 28) - 2*qy*qy - 2*qz*qz;
    m[0][1] = 2*qx*qy - 2*qz*qw;
    m[0][2] = 2*qx*qz + 2*qy*qw;
    m[1][0] = 2*qx*qy + 2*qz*qw;
    m[1][1] = (64'sd1 <<< 28) - 2*qx*qx - 2*qz*qz;
    m[1][2] = 2*qy*qz - 2*qx*qw;
    m[2][0] = 2*qx*qz - 2*qy*qw;
    m[2][1] = 2*qy*qz + 2*qx*qw;
    m[2][2] = (64'sd1 <<< 28) - 2*qx*qx - 2*qy*qy;
    c[0] = longint'($signed(d[CW-1:0]));
    c[1] = longint'($signed(d[2*CW-1:CW]));
    c[2] = longint'($signed(d[3*CW-1:2*CW]));
    for (int i = 0; i < 3; i++) begin
      r[i] = (m[i][0]*c[0] + m[i][1]*c[1] + m[i][2]*c[2] + (64'sd1 <<< 27)) >>> 28;
    end
    if (range_sq != 0) begin
      d2 = 0;
      for (int i = 0; i < 3; i++) begin
        a = (r[i] < 0) ? -r[i] : r[i];
        if (a > 64'sh00FF_FFFF) return 1'b0;
        d2 += a * a;
      end
      if (d2 > longint'({16'd0, range_sq})) return 1'b0;
    end
    w[0] = sat_coord(r[0] + longint'($signed(shift_x)));
    w[1] = sat_coord(r[1] + longint'($signed(shift_y)));
    w[2] = sat_coord(r[2] + longint'($signed(shift_z)));

    raw_i = longint'(d[3*CW+15:3*CW]);
    off = longint'(int_limits[31:16]);
    span = longint'(int_limits[15:0]);
    if (!int_limits[32]) begin
      norm = 32768;
      gray = 127;
    end else if (span == 0) begin
      norm = (raw_i == 0) ? 0 : 65535;
      gray = (raw_i == 0) ? 0 : 255;
    end else if (raw_i <= off) begin
      norm = 0;
      gray = 0;
    end else begin
      norm = ((raw_i - off) <<< 16) / span;
      gray = ((raw_i - off) * 255) / span;
      if (norm > 65535) norm = 65535;
      if (gray > 255) gray = 255;
    end

    rgb[0] = 0; rgb[1] = 0; rgb[2] = 0;
    if (col_offs[48]) begin
      rgb[0] = scale_chan(longint'(d[3*CW+31:3*CW+16]), longint'(col_offs[47:32]),
                          longint'(col_spans[47:32]));
      rgb[1] = scale_chan(longint'(d[3*CW+47:3*CW+32]), longint'(col_offs[31:16]),
                          longint'(col_spans[31:16]));
      rgb[2] = scale_chan(longint'(d[3*CW+63:3*CW+48]), longint'(col_offs[15:0]),
                          longint'(col_spans[15:0]));
    end
    // gray fallback for absent or all-black color
    if (rgb[0] == 0 && rgb[1] == 0 && rgb[2] == 0) begin
      rgb[0] = gray; rgb[1] = gray; rgb[2] = gray;
    end
    res = '0;
    res[CW-1:0] = w[0][CW-1:0];
    res[2*CW-1:CW] = w[1][CW-1:0];
    res[3*CW-1:2*CW] = w[2][CW-1:0];
    res[3*CW+15:3*CW] = norm[15:0];
    res[3*CW+23:3*CW+16] = rgb[0][7:0];
    res[3*CW+31:3*CW+24] = rgb[1][7:0];
    res[3*CW+39:3*CW+32] = rgb[2][7:0];
    return 1'b1;
  endfunction

  // driver: bursts with random gaps, prediction on each accepted beat
  always @(posedge clk) begin
    logic [MWD-1:0] res;
    logic [SW-1:0] nd;
    logic nv;
    if (rst) begin
      s_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (transform_point(s_tdata, res)) world_q = {world_q, res};
      end
      if (!s_tvalid || s_tready) begin
        nv = 1'b0;
        nd = s_tdata;
        if (gap_left > 0) begin
          gap_left--;
        end else if (point_q.size() > 0) begin
          nd = point_q.pop_front();
          nv = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
        s_tvalid <= nv;
        s_tdata <= nd;
      end
    end
  end

  // monitor: receiver stalls on its own pattern, checks each beat in order
  always @(posedge clk) begin
    logic [MWD-1:0] want;
    if (rst) begin
      m_tready <= 1'b0;
      stall_mode = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (world_q.size() == 0) begin
          report("unexpected beat", longint'(m_tdata[63:0]), 0);
        end else begin
          want = world_q.pop_front();
          if (m_tdata[CW-1:0] !== want[CW-1:0])
            report("world_x", m_tdata[CW-1:0], want[CW-1:0]);
          if (m_tdata[2*CW-1:CW] !== want[2*CW-1:CW])
            report("world_y", m_tdata[2*CW-1:CW], want[2*CW-1:CW]);
          if (m_tdata[3*CW-1:2*CW] !== want[3*CW-1:2*CW])
            report("world_z", m_tdata[3*CW-1:2*CW], want[3*CW-1:2*CW]);
          if (m_tdata[3*CW+15:3*CW] !== want[3*CW+15:3*CW])
            report("norm_intensity", m_tdata[3*CW+15:3*CW], want[3*CW+15:3*CW]);
          if (m_tdata[3*CW+23:3*CW+16] !== want[3*CW+23:3*CW+16])
            report("red_out", m_tdata[3*CW+23:3*CW+16], want[3*CW+23:3*CW+16]);
          if (m_tdata[3*CW+31:3*CW+24] !== want[3*CW+31:3*CW+24])
            report("green_out", m_tdata[3*CW+31:3*CW+24], want[3*CW+31:3*CW+24]);
          if (m_tdata[3*CW+39:3*CW+32] !== want[3*CW+39:3*CW+32])
            report("blue_out", m_tdata[3*CW+39:3*CW+32], want[3*CW+39:3*CW+32]);
        end
      end
      if (cycles % 64 == 0) stall_mode = $urandom_range(0, 2);
      case (stall_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 1) == 1);
        default: m_tready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL point_pose_transform_normalize_top");
      $finish;
    end
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_POSE_QUAT:   pose_q = val;
      REG_SHIFT_X:     shift_x = val[CW-1:0];
      REG_SHIFT_Y:     shift_y = val[CW-1:0];
      REG_SHIFT_Z:     shift_z = val[CW-1:0];
      REG_RANGE_LIMIT: range_sq = val[47:0];
      REG_INT_LIMITS:  int_limits = val[32:0];
      REG_COLOR_OFFS:  col_offs = val[48:0];
      default:         col_spans = val[47:0];
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // wait out pending beats plus pipeline depth, since dropped points leave no trace
  task automatic drain();
    while (point_q.size() != 0 || world_q.size() != 0 || s_tvalid) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic add_point(input logic [SW-1:0] p);
    point_q = {point_q, p};
  endtask

  function automatic logic [SW-1:0] make_point(input logic [CW-1:0] x, y, z,
                                                input logic [15:0] ri, rr, rg, rb);
    return {rb, rg, rr, ri, z, y, x};
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    if ($urandom_range(0, 9) < 7) return CW'($signed($urandom_range(0, 8192)) - 4096);
    return CW'($urandom);
  endfunction

  function automatic logic [SW-1:0] rand_point();
    logic [15:0] rr, rg, rb;
    rr = $urandom; rg = $urandom; rb = $urandom;
    if ($urandom_range(0, 9) == 0) begin
      rr = 0; rg = 0; rb = 0;
    end
    return make_point(rand_coord(), rand_coord(), rand_coord(), 16'($urandom), rr, rg, rb);
  endfunction

  function automatic logic [15:0] rand_qc();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  initial begin
    logic [CW-1:0] cmax, cmin;
    logic [63:0] v;
    cmax = {1'b0, {(CW-1){1'b1}}};
    cmin = {1'b1, {(CW-1){1'b0}}};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    errors = 0;
    cycles = 0;
    pose_q = 64'h4000_0000_0000_0000;
    shift_x = '0; shift_y = '0; shift_z = '0;
    range_sq = '0; int_limits = '0; col_offs = '0; col_spans = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed points under reset settings: identity pose, intensity absent
    add_point(make_point(cmax, cmax, cmax, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    add_point(make_point(cmin, cmin, cmin, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    add_point(make_point('0, '0, '0, 16'h0001, 16'h0000, 16'h0000, 16'h0000));
    add_point(make_point(cmax, cmin, '0, 16'h8000, 16'h1234, 16'h0, 16'hFFFF));
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: v = 64'h4000_0000_0000_0000;
        1: v = 64'h8000_8000_8000_8000;
        2: v = 64'h7FFF_7FFF_7FFF_7FFF;
        3: v = {$urandom, $urandom};
        default: v = {rand_qc(), rand_qc(), rand_qc(), rand_qc()};
      endcase
      write_reg(REG_POSE_QUAT, v);
      write_reg(REG_SHIFT_X, (p == 1) ? 64'(cmax) : (p == 2) ? 64'(cmin) : 64'($urandom));
      write_reg(REG_SHIFT_Y, (p == 1) ? 64'(cmin) : (p == 2) ? 64'(cmax) : 64'($urandom));
      write_reg(REG_SHIFT_Z, (p == 1) ? 64'(cmax) : (p == 2) ? 64'(cmin) : 64'($urandom));
      case (p % 4)
        0: v = 0;
        1: v = 64'hFFFF_FFFF_FFFF;
        2: v = 64'($urandom_range(1, 30000000));
        default: v = {16'd0, 16'($urandom), 32'($urandom)};
      endcase
      write_reg(REG_RANGE_LIMIT, v);
      case (p)
        0: v = 0;
        3: v = {31'd0, 1'b1, 16'($urandom), 16'd0};
        5: v = {31'd0, 1'b1, 16'hFFFF, 16'($urandom)};
        7: v = {31'd0, 1'b1, 16'd0, 16'hFFFF};
        default: v = {31'd0, 1'b1, 16'($urandom_range(0, 20000)), 16'($urandom)};
      endcase
      write_reg(REG_INT_LIMITS, v);
      write_reg(REG_COLOR_OFFS, (p % 4 == 1) ? {15'd0, 1'b0, 16'($urandom), 32'($urandom)}
                                             : {15'd0, 1'b1, 16'($urandom_range(0, 20000)),
                                                16'($urandom_range(0, 20000)),
                                                16'($urandom_range(0, 20000))});
      write_reg(REG_COLOR_SPANS, (p == 5) ? 64'd0 : (p == 6) ? 64'hFFFF_FFFF_FFFF
                                            : {16'd0, 16'($urandom), 32'($urandom)});
      repeat (4) @(posedge clk);
      if (p == 3) begin
        // intensity span zero: raw zero and nonzero
        add_point(make_point('0, '0, '0, 16'h0000, 16'h0, 16'h0, 16'h0));
        add_point(make_point('0, '0, '0, 16'h0001, 16'h0, 16'h0, 16'h0));
      end
      if (p == 7) begin
        add_point(make_point(16'd100, 16'd0, 16'd0, 16'h0000, 16'h0, 16'h0, 16'h0));
        add_point(make_point(16'd100, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'h0, 16'h0));
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) add_point(rand_point());
      drain();
    end

    if (errors == 0) begin
      $display("PASS point_pose_transform_normalize_top");
    end else begin
      $display("FAIL point_pose_transform_normalize_top");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/pptn_pkg.sv
design/pptn_div.sv
design/point_pose_transform_normalize_top.sv
tb/point_pose_transform_normalize_top_tb.sv
